>>> rtl/itfa_pkg.sv
// ----------------------------------------------------------------------------
// itfa_pkg
// Shared constants and types of the idle timeout frame assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package itfa_pkg;

  // frame store size and derived widths
  localparam int FRAME_DEPTH = 64;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int FILL_W      = $clog2(FRAME_DEPTH + 1);

  // fixed field widths
  localparam int TIME_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 7;
  localparam int LEN_W   = 7;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // input kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // configuration register indexes
  localparam logic REG_IDLE_TIMEOUT = 1'b0;
  localparam logic REG_FRAME_LIMIT  = 1'b1;

  // reset values of the configuration registers
  localparam logic [TIME_W-1:0]  IDLE_TIMEOUT_RST = 32'd1000;
  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST  = 7'd64;

  // command from front to back: store one byte or read out a frame
  typedef struct packed {
    logic              flush;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic [FILL_W-1:0] len;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/idle_timeout_frame_assembler_core.sv
// ----------------------------------------------------------------------------
// idle_timeout_frame_assembler_core
// Gathers received bytes into a frame and streams the frame out once a poll
// sees a silence longer than the configured idle timeout.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       tdata: now_time, rx_byte; tuser: opcode
//  m_*       out  m_tvalid / m_tready       tdata: frame_byte, frame_length; tlast
//  cfg_*     in   cfg_we (no wait)          cfg_index, cfg_data
//
//  an input beat is taken each cycle while the two-entry command queue has
//  room; the back stores each byte in a single step, so bytes sustain one a cycle
//  while no frame is streaming out; a closed frame of n bytes streams out at one
//  beat per cycle while the output buffer has room: the back takes the command,
//  then reads the n bytes, paced by the frame store read port; polls queue up behind it
//  rst is synchronous; no clearing pass, the store needs none
//  output stalls hold the back; the front keeps accepting until the queue fills
// ----------------------------------------------------------------------------
`default_nettype none

module idle_timeout_frame_assembler_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // now_time [31:0], rx_byte [39:32]
  input  wire  [0:0]  s_tuser,   // opcode [0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // frame_byte [7:0], frame_length [14:8], zero [15]
  output logic        m_tlast
);

  itfa_pkg::cmd_t               push_cmd;
  itfa_pkg::cmd_t               head_cmd;
  logic                         cmd_push;
  logic                         cmd_full;
  logic                         cmd_pop;
  logic                         cmd_valid;
  logic [itfa_pkg::BYTE_W-1:0]  frame_byte;
  logic [itfa_pkg::LEN_W-1:0]   frame_length;

  // front: accept and classify
  itfa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .opcode    (s_tuser[0]),
    .now_time  (s_tdata[31:0]),
    .rx_byte   (s_tdata[39:32]),
    .cmd_push  (cmd_push),
    .cmd       (push_cmd),
    .cmd_full  (cmd_full)
  );

  // command queue
  itfa_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_cmd  (push_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .head      (head_cmd)
  );

  // back: store and readout
  itfa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (head_cmd),
    .cmd_pop       (cmd_pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .frame_byte    (frame_byte),
    .frame_length  (frame_length),
    .last_of_frame (m_tlast)
  );

  assign m_tdata = {1'b0, frame_length, frame_byte};

endmodule

`default_nettype wire

>>> rtl/itfa_ram.sv
// ----------------------------------------------------------------------------
// itfa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module itfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire                     rd_en,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/itfa_cmd_fifo.sv
// ----------------------------------------------------------------------------
// itfa_cmd_fifo
// Short register queue of commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module itfa_cmd_fifo (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  itfa_pkg::cmd_t push_cmd,
  output logic          full,
  input  wire           pop,
  output logic          not_empty,
  output itfa_pkg::cmd_t head
);

  itfa_pkg::cmd_t                  slots [itfa_pkg::Q_DEPTH];
  logic [itfa_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [itfa_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [itfa_pkg::Q_CNT_W-1:0]    count;
  logic                            do_push;
  logic                            do_pop;

  assign full      = (count == itfa_pkg::Q_CNT_W'(itfa_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer wrap
  function automatic logic [itfa_pkg::Q_PTR_W-1:0] ptr_inc(
    input logic [itfa_pkg::Q_PTR_W-1:0] p
  );
    if (p == itfa_pkg::Q_PTR_W'(itfa_pkg::Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/itfa_front.sv
// ----------------------------------------------------------------------------
// itfa_front
// Accepts bytes and polls, tracks fill count and last byte time, and issues
// store and readout commands.
// ----------------------------------------------------------------------------
`default_nettype none

module itfa_front (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire                              cfg_index,
  input  wire [itfa_pkg::TIME_W-1:0]       cfg_data,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              opcode,
  input  wire [itfa_pkg::TIME_W-1:0]       now_time,
  input  wire [itfa_pkg::BYTE_W-1:0]       rx_byte,
  output logic                             cmd_push,
  output itfa_pkg::cmd_t                   cmd,
  input  wire                              cmd_full
);

  logic [itfa_pkg::TIME_W-1:0]  idle_timeout;
  logic [itfa_pkg::LIMIT_W-1:0] frame_limit;
  logic [itfa_pkg::FILL_W-1:0]  fill_count;
  logic [itfa_pkg::FILL_W-1:0]  fill_count_next;
  logic [itfa_pkg::TIME_W-1:0]  last_rx_time;
  logic [itfa_pkg::FILL_W-1:0]  lim;
  logic [itfa_pkg::ADDR_W-1:0]  wr_idx;
  logic [itfa_pkg::TIME_W-1:0]  silence;
  logic                         accept;
  logic                         timed_out;

  assign in_ready = !cmd_full;
  assign accept   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= itfa_pkg::IDLE_TIMEOUT_RST;
      frame_limit  <= itfa_pkg::FRAME_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        itfa_pkg::REG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
        itfa_pkg::REG_FRAME_LIMIT:  frame_limit  <= cfg_data[itfa_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limit, store slot and silence check
  always_comb begin
    priority if (frame_limit == '0) begin
      lim = itfa_pkg::FILL_W'(1);
    end else if (frame_limit > itfa_pkg::LIMIT_W'(itfa_pkg::FRAME_DEPTH)) begin
      lim = itfa_pkg::FILL_W'(itfa_pkg::FRAME_DEPTH);
    end else begin
      lim = itfa_pkg::FILL_W'(frame_limit);
    end
    if (fill_count >= lim) begin
      wr_idx = itfa_pkg::ADDR_W'(lim - 1'b1);
    end else begin
      wr_idx = itfa_pkg::ADDR_W'(fill_count);
    end
    silence   = now_time - last_rx_time;
    timed_out = (fill_count != '0) && (silence > idle_timeout);
  end

  // command to the back
  always_comb begin
    cmd.flush       = (opcode == itfa_pkg::OP_POLL);
    cmd.addr        = wr_idx;
    cmd.data        = rx_byte;
    cmd.len         = fill_count;
    cmd_push        = accept && ((opcode == itfa_pkg::OP_BYTE) || timed_out);
    fill_count_next = fill_count;
    if (accept) begin
      if (opcode == itfa_pkg::OP_BYTE) begin
        fill_count_next = itfa_pkg::FILL_W'(wr_idx) + 1'b1;
      end else if (timed_out) begin
        fill_count_next = '0;
      end
    end
  end

  // frame tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      last_rx_time <= '0;
    end else begin
      fill_count <= fill_count_next;
      if (accept && (opcode == itfa_pkg::OP_BYTE)) begin
        last_rx_time <= now_time;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/itfa_back.sv
// ----------------------------------------------------------------------------
// itfa_back
// Executes queued commands on the frame store: stores bytes and streams out
// closed frames through a two-entry output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module itfa_back (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cmd_valid,
  input  itfa_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [itfa_pkg::BYTE_W-1:0]  frame_byte,
  output logic [itfa_pkg::LEN_W-1:0]   frame_length,
  output logic                         last_of_frame
);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_READ = 2'b10
  } bk_state_t;

  typedef struct packed {
    logic [itfa_pkg::BYTE_W-1:0] data;
    logic [itfa_pkg::FILL_W-1:0] len;
    logic                        last;
  } ent_t;

  bk_state_t                    state;
  bk_state_t                    state_next;
  logic [itfa_pkg::ADDR_W-1:0]  rd_idx;
  logic [itfa_pkg::FILL_W-1:0]  len;
  logic                         wr_en;
  logic                         rd_en;
  logic                         rd_last;
  logic [itfa_pkg::BYTE_W-1:0]  rd_data;
  logic                         inflight;
  logic [itfa_pkg::FILL_W-1:0]  inflight_len;
  logic                         inflight_last;
  logic                         skid_valid;
  ent_t                         out_ent;
  ent_t                         skid_ent;
  ent_t                         arr_ent;
  logic                         pop;
  logic [1:0]                   occ;
  logic                         room;

  itfa_ram #(
    .WIDTH (itfa_pkg::BYTE_W),
    .DEPTH (itfa_pkg::FRAME_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cmd.addr),
    .wr_data (cmd.data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  // buffer occupancy including the read in flight
  assign pop  = out_valid && out_ready;
  assign occ  = 2'(out_valid) + 2'(skid_valid) + 2'(inflight);
  assign room = (occ - 2'(pop)) < 2'd2;

  // command sequencing
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_last    = (itfa_pkg::FILL_W'(rd_idx) + 1'b1) == len;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.flush) begin
            state_next = BK_READ;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      BK_READ: begin
        if (room) begin
          rd_en = 1'b1;
          if (rd_last) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // sequencer state and read flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      inflight <= 1'b0;
    end else begin
      state    <= state_next;
      inflight <= rd_en;
    end
  end

  // readout index, frame length and read meta
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && cmd_valid && cmd.flush) begin
      len    <= cmd.len;
      rd_idx <= '0;
    end else if (rd_en) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (rd_en) begin
      inflight_len  <= len;
      inflight_last <= rd_last;
    end
  end

  assign arr_ent = '{data: rd_data, len: inflight_len, last: inflight_last};

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        out_ent   <= skid_ent;
        if (inflight) begin
          skid_ent <= arr_ent;
        end else begin
          skid_valid <= 1'b0;
        end
      end else if (inflight) begin
        out_valid <= 1'b1;
        out_ent   <= arr_ent;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (inflight) begin
      skid_valid <= 1'b1;
      skid_ent   <= arr_ent;
    end
  end

  assign frame_byte    = out_ent.data;
  assign frame_length  = itfa_pkg::LEN_W'(out_ent.len);
  assign last_of_frame = out_ent.last;

  // buffer never overflows
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    $countones({out_valid, skid_valid, inflight}) <= 2)
    else $error("readout buffer over capacity");

  // arriving read data always finds a free place
  a_arrival_room: assert property (@(posedge clk) disable iff (rst)
    inflight |-> !(out_valid && skid_valid && !pop))
    else $error("read data arrived into a full buffer");

  // last read of a frame returns the sequencer to idle
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (rd_en && rd_last) |=> (state == BK_IDLE))
    else $error("readout continued past frame end");

  // skid holds data only behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds data with empty output register");

endmodule

`default_nettype wire

>>> tb/idle_timeout_frame_assembler_core_tb.sv
// ----------------------------------------------------------------------------
// idle_timeout_frame_assembler_core_tb
// Drives received bytes and idle polls into the frame assembler. A predictor
// in the bench tracks the frame store, fill count and last byte time, and
// turns each accepted poll into the frame beats that must come out. Output
// beats are checked in order. Both sides idle and stall at random, and the
// run covers several timeout and frame limit settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idle_timeout_frame_assembler_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct packed {
    logic        op;
    logic [31:0] now_time;
    logic [7:0]  rx_data;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [6:0] len;
    logic       last;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // now_time [31:0], rx_byte [39:32]
  logic [0:0]  s_tuser = '0;   // opcode [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // frame_byte [7:0], frame_length [14:8], zero [15]
  logic        m_tlast;

  // stimulus and expectation stores
  rx_item_t    rx_pending[$];
  frame_beat_t frame_beats_due[$];
  rx_item_t    next_item;
  frame_beat_t due_beat;

  // predictor state
  logic [7:0]  pred_store [itfa_pkg::FRAME_DEPTH];
  int          pred_fill = 0;
  logic [31:0] pred_last_time = '0;
  logic [31:0] pred_timeout = itfa_pkg::IDLE_TIMEOUT_RST;
  logic [6:0]  pred_limit = itfa_pkg::FRAME_LIMIT_RST;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int items_queued = 0;

  idle_timeout_frame_assembler_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // frame assembly predictor: store a byte, or close the frame on a long silence
  function automatic void assemble_step(logic op, logic [31:0] now, logic [7:0] rx);
    int          lim;
    logic [31:0] silence;
    frame_beat_t b;
    if (op == itfa_pkg::OP_BYTE) begin
      lim = pred_limit;
      if (lim == 0) lim = 1;
      if (lim > itfa_pkg::FRAME_DEPTH) lim = itfa_pkg::FRAME_DEPTH;
      if (pred_fill >= lim) pred_fill = lim - 1;
      pred_store[pred_fill] = rx;
      pred_fill++;
      pred_last_time = now;
    end else begin
      silence = now - pred_last_time;
      if (pred_fill > 0 && silence > pred_timeout) begin
        for (int k = 0; k < pred_fill; k++) begin
          b.data = pred_store[k];
          b.len  = 7'(pred_fill);
          b.last = (k + 1 == pred_fill);
          frame_beats_due.push_back(b);
        end
        pred_fill = 0;
      end
    end
  endfunction

  // driver: predict on each accepted beat, then offer the next pending item
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        assemble_step(s_tuser[0], s_tdata[31:0], s_tdata[39:32]);
      if (!s_tvalid || s_tready) begin
        if (rx_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = rx_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {next_item.rx_data, next_item.now_time};
          s_tuser  <= next_item.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: compare each output beat with the oldest expected beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (frame_beats_due.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual data %h len %0d last %b",
                 $time, m_tdata[7:0], m_tdata[14:8], m_tlast);
        mismatches++;
      end else begin
        due_beat = frame_beats_due.pop_front();
        if (m_tdata[7:0] !== due_beat.data) begin
          $display("%0t: frame_byte mismatch: expected %h actual %h",
                   $time, due_beat.data, m_tdata[7:0]);
          mismatches++;
        end
        if (m_tdata[14:8] !== due_beat.len) begin
          $display("%0t: frame_length mismatch: expected %0d actual %0d",
                   $time, due_beat.len, m_tdata[14:8]);
          mismatches++;
        end
        if (m_tlast !== due_beat.last) begin
          $display("%0t: last_of_frame mismatch: expected %b actual %b",
                   $time, due_beat.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("idle_timeout_frame_assembler_core_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(logic op, logic [31:0] now, logic [7:0] rx);
    rx_item_t it;
    it.op = op;
    it.now_time = now;
    it.rx_data = rx;
    rx_pending.push_back(it);
    items_queued++;
  endtask

  // wait until every item is taken and every expected beat has arrived
  task automatic wait_drained(int settle);
    while (rx_pending.size() > 0 || s_tvalid || frame_beats_due.size() > 0)
      @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == itfa_pkg::REG_IDLE_TIMEOUT) pred_timeout = val;
    else pred_limit = val[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one well-formed frame: bytes, maybe early polls, then a closing poll
  task automatic gen_frame(int nbytes, logic [31:0] tmo);
    logic [31:0] t;
    int          step_max;
    int          slack;
    t = $urandom;
    step_max = (tmo > 1000) ? 1000 : int'(tmo);
    for (int k = 0; k < nbytes; k++) begin
      t = t + $urandom_range(0, step_max);
      push_item(itfa_pkg::OP_BYTE, t, 8'($urandom));
    end
    repeat ($urandom_range(0, 2))
      push_item(itfa_pkg::OP_POLL, t + $urandom_range(0, tmo), 8'($urandom));
    slack = (32'hFFFF_FFFF - tmo > 101) ? 100 : 0;
    push_item(itfa_pkg::OP_POLL, t + tmo + 1 + $urandom_range(0, slack), 8'($urandom));
  endtask

  // random phase: mostly frames, some stray bytes and polls
  task automatic run_phase(int budget, int n_lo, int n_hi, logic [31:0] tmo);
    int start;
    start = items_queued;
    while (items_queued - start < budget) begin
      if ($urandom_range(99) < 15)
        push_item(1'($urandom), $urandom, 8'($urandom));
      else
        gen_frame($urandom_range(n_lo, n_hi), tmo);
    end
  endtask

  initial begin
    logic [31:0] t0;
    logic [31:0] tmo;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, empty poll, timeout boundary, wrap of time
    t0 = $urandom;
    push_item(itfa_pkg::OP_POLL, t0, 8'hFF);
    push_item(itfa_pkg::OP_BYTE, t0, 8'h00);
    push_item(itfa_pkg::OP_BYTE, t0 + 5, 8'hFF);
    push_item(itfa_pkg::OP_BYTE, t0 + 10, 8'hA5);
    push_item(itfa_pkg::OP_POLL, t0 + 1010, 8'hFF);
    push_item(itfa_pkg::OP_POLL, t0 + 1011, 8'hFF);
    push_item(itfa_pkg::OP_BYTE, 32'hFFFF_FFF0, 8'h5A);
    push_item(itfa_pkg::OP_POLL, 32'h0000_03D9, 8'h00);
    push_item(itfa_pkg::OP_BYTE, 32'hFFFF_FFFF, 8'h3C);
    push_item(itfa_pkg::OP_BYTE, 32'h0000_0000, 8'hC3);
    push_item(itfa_pkg::OP_POLL, 32'd1001, 8'h00);
    wait_drained(SETTLE_CYCLES);

    // frame limit of one, then zero: only the newest byte survives
    write_reg(itfa_pkg::REG_FRAME_LIMIT, 32'd1);
    push_item(itfa_pkg::OP_BYTE, t0, 8'h11);
    push_item(itfa_pkg::OP_BYTE, t0 + 1, 8'h22);
    push_item(itfa_pkg::OP_POLL, t0 + 2000, 8'h00);
    wait_drained(SETTLE_CYCLES);
    write_reg(itfa_pkg::REG_FRAME_LIMIT, 32'd0);
    push_item(itfa_pkg::OP_BYTE, t0, 8'h44);
    push_item(itfa_pkg::OP_BYTE, t0 + 1, 8'h55);
    push_item(itfa_pkg::OP_POLL, t0 + 2000, 8'h00);
    wait_drained(SETTLE_CYCLES);

    // limit lowered below the fill count of an open frame
    write_reg(itfa_pkg::REG_FRAME_LIMIT, 32'd64);
    for (int k = 1; k <= 4; k++) push_item(itfa_pkg::OP_BYTE, t0 + k, 8'(k));
    wait_drained(SETTLE_CYCLES);
    write_reg(itfa_pkg::REG_FRAME_LIMIT, 32'd2);
    push_item(itfa_pkg::OP_BYTE, t0 + 9, 8'h99);
    push_item(itfa_pkg::OP_POLL, t0 + 2000, 8'h00);
    wait_drained(SETTLE_CYCLES);

    // timeout extremes: all ones never closes, zero closes after one tick
    write_reg(itfa_pkg::REG_IDLE_TIMEOUT, 32'hFFFF_FFFF);
    push_item(itfa_pkg::OP_BYTE, t0, 8'h77);
    push_item(itfa_pkg::OP_POLL, t0 - 1, 8'h00);
    wait_drained(SETTLE_CYCLES);
    write_reg(itfa_pkg::REG_IDLE_TIMEOUT, 32'd0);
    push_item(itfa_pkg::OP_POLL, t0, 8'h00);
    push_item(itfa_pkg::OP_POLL, t0 + 1, 8'h00);
    wait_drained(SETTLE_CYCLES);

    // no idling, small timeout, full limit
    tmo = $urandom_range(1, 100);
    write_reg(itfa_pkg::REG_IDLE_TIMEOUT, tmo);
    write_reg(itfa_pkg::REG_FRAME_LIMIT, 32'd64);
    run_phase(4, 1, 8, tmo);
    wait_drained(SETTLE_CYCLES);

    // sender mostly idle, limit of four so frames saturate
    send_idle_pct = 84;
    tmo = $urandom_range(0, 200);
    write_reg(itfa_pkg::REG_IDLE_TIMEOUT, tmo);
    write_reg(itfa_pkg::REG_FRAME_LIMIT, 32'd4);
    run_phase(4, 1, 8, tmo);
    wait_drained(SETTLE_CYCLES);

    // receiver mostly stalled, limit above the store size, one overlong frame
    send_idle_pct = 0;
    recv_stall_pct = 84;
    write_reg(itfa_pkg::REG_IDLE_TIMEOUT, 32'd0);
    write_reg(itfa_pkg::REG_FRAME_LIMIT, 32'd127);
    gen_frame(65, 32'd0);
    wait_drained(SETTLE_CYCLES);

    // both sides idle at times, limit zero, large timeout
    send_idle_pct = 31;
    recv_stall_pct = 31;
    tmo = $urandom_range(32'h0001_0000, 32'h7FFF_FFFF);
    write_reg(itfa_pkg::REG_IDLE_TIMEOUT, tmo);
    write_reg(itfa_pkg::REG_FRAME_LIMIT, 32'd0);
    run_phase(4, 1, 5, tmo);
    wait_drained(SETTLE_CYCLES);

    // long receiver hold while the sender keeps offering, then a full pause
    send_idle_pct = 0;
    recv_stall_pct = 0;
    tmo = 32'd10;
    write_reg(itfa_pkg::REG_IDLE_TIMEOUT, tmo);
    write_reg(itfa_pkg::REG_FRAME_LIMIT, 32'd64);
    hold_req++;
    gen_frame(5, tmo);
    gen_frame(2, tmo);
    run_phase(2, 1, 4, tmo);
    wait_drained(0);
    run_phase(4, 2, 10, tmo);
    wait_drained(SETTLE_CYCLES);

    if (mismatches == 0 && frame_beats_due.size() == 0) begin
      $display("idle_timeout_frame_assembler_core_tb OK");
    end else begin
      $display("idle_timeout_frame_assembler_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/itfa_pkg.sv
rtl/itfa_ram.sv
rtl/itfa_cmd_fifo.sv
rtl/itfa_front.sv
rtl/itfa_back.sv
rtl/idle_timeout_frame_assembler_core.sv
tb/idle_timeout_frame_assembler_core_tb.sv
